FILE: rtl/lcs_pkg.sv
package lcs_pkg;

    // storage and field sizes
    localparam int MAX_WAYS = 8;
    localparam int TAG_BITS = 20;
    localparam int TAG_W    = 20;
    localparam int STATE_W  = 3;
    localparam int WAYS_W   = 4;
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int CMP_W    = (CNT_W > WAYS_W) ? CNT_W : WAYS_W;

    localparam logic [WAYS_W-1:0]  WAYS_RESET = WAYS_W'(8);
    localparam logic [STATE_W-1:0] STATE_I    = '0;

    // register indexes
    localparam logic REG_WAYS = 1'b0;

    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [STATE_W-1:0]  t_state;

    typedef enum logic [2:0] {
        OP_LOOKUP     = 3'd0,
        OP_READ_TOUCH = 3'd1,
        OP_UPDATE     = 3'd2,
        OP_SET_STATE  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_INVALIDATE = 3'd5
    } t_op;

    // decoded request broadcast to every cell
    typedef struct packed {
        logic   en;
        logic   touch;
        logic   use_ns;
        logic   set_st;
        logic   ins;
        logic   inv;
        logic   evict;
        t_tag   tag;
        t_state new_state;
    } t_req;

    // one line as held by a cell
    typedef struct packed {
        logic   valid;
        t_tag   tag;
        t_state state;
    } t_line;

    // match chain running from oldest to newest
    typedef struct packed {
        logic   found;
        t_state fstate;
    } t_link;

endpackage

FILE: rtl/lcs_cell.sv
module lcs_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lcs_pkg::t_req  i_req,
    input  logic           i_prev_valid,
    input  lcs_pkg::t_link i_link,
    input  lcs_pkg::t_line i_nb,
    output lcs_pkg::t_line o_line,
    output lcs_pkg::t_link o_link
);

    logic              r_valid;
    lcs_pkg::t_tag     r_tag;
    lcs_pkg::t_state   r_state;
    logic              n_valid;
    lcs_pkg::t_tag     n_tag;
    lcs_pkg::t_state   n_state;
    logic              w_match;
    logic              w_last;

    assign w_match = r_valid && (r_tag == i_req.tag);
    assign w_last  = r_valid && !i_nb.valid;

    assign o_link.found  = i_link.found || w_match;
    assign o_link.fstate = i_link.found ? i_link.fstate
                         : (w_match ? r_state : lcs_pkg::STATE_I);

    assign o_line.valid = r_valid;
    assign o_line.tag   = r_tag;
    assign o_line.state = r_state;

    always_comb begin
        n_valid = r_valid;
        n_tag   = r_tag;
        n_state = r_state;
        if (i_req.en) begin
            // touch: lines from the match on move one step older, match goes last
            if (i_req.touch && o_link.found && r_valid) begin
                if (w_last) begin
                    n_tag   = i_req.tag;
                    n_state = i_req.use_ns ? i_req.new_state : o_link.fstate;
                end else begin
                    n_tag   = i_nb.tag;
                    n_state = i_nb.state;
                end
            end
            // remove: close the gap, newest cell empties
            if (i_req.inv && o_link.found && r_valid) begin
                if (w_last) begin
                    n_valid = 1'b0;
                end else begin
                    n_tag   = i_nb.tag;
                    n_state = i_nb.state;
                end
            end
            if (i_req.set_st && w_match) begin
                n_state = i_req.new_state;
            end
            if (i_req.ins) begin
                if (i_req.evict) begin
                    if (r_valid) begin
                        if (w_last) begin
                            n_tag   = i_req.tag;
                            n_state = i_req.new_state;
                        end else begin
                            n_tag   = i_nb.tag;
                            n_state = i_nb.state;
                        end
                    end
                end else if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_tag   = i_req.tag;
                    n_state = i_req.new_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_tag   <= n_tag;
        r_state <= n_state;
    end

endmodule

FILE: rtl/lru_cache_set_with_line_state_unit.sv
// lru cache set with per-line coherence state
// input stream (s_*): one request word per handshake; s_tuser carries the
//   request type, s_tdata carries the tag and the new state
// output stream (m_*): one result word per request, in request order
// config (apb): register 0 is ways_in_use, the line limit before insert evicts
// lines sit in a row of cells ordered oldest (cell 0) to newest; a request
//   is applied to all cells in the accepting cycle, with the match and the
//   shift data passed from cell to cell
// latency: the result word is valid the cycle after the request is accepted
// throughput: one request per cycle unless a result word stalls; the single cell-row
//   update per cycle sets that figure, and s_tready follows m_tready in the same cycle
// a stalled receiver holds the result word; a new request is taken only in
//   a cycle where the waiting word is taken at the same time
// reset: the set is empty, ways_in_use reads 8, no result is pending
module lru_cache_set_with_line_state_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // tag[19:0], new_state[22:20], zero[23]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // hit[0], found_state[3:1], set_full[4],
                                   // set_empty[5], oldest_valid[6],
                                   // oldest_tag[26:7], oldest_state[29:27], zero[31:30]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MW = lcs_pkg::MAX_WAYS;

    logic [lcs_pkg::WAYS_W-1:0] r_ways;
    logic [lcs_pkg::CNT_W-1:0]  r_count;
    logic [lcs_pkg::CNT_W-1:0]  n_count;
    logic                       r_m_tvalid;
    logic                       r_hit;
    lcs_pkg::t_state            r_fstate;

    logic                       w_accept;
    logic                       w_cfg_wr;
    logic [lcs_pkg::CMP_W-1:0]  w_ways_ext;
    logic [lcs_pkg::CMP_W-1:0]  w_limit;
    logic [lcs_pkg::CMP_W-1:0]  w_count_ext;
    lcs_pkg::t_req              w_req;
    lcs_pkg::t_line             w_line [MW];
    lcs_pkg::t_link             w_link [MW];
    lcs_pkg::t_line             w_oldest;
    logic                       w_hit;

    // handshakes
    assign w_accept = s_tvalid && s_tready;
    assign s_tready = !r_m_tvalid || m_tready;
    assign m_tvalid = r_m_tvalid;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == lcs_pkg::REG_WAYS) ? 32'(r_ways) : 32'd0;

    // effective limit: zero acts as one, above storage acts as storage size
    assign w_ways_ext  = lcs_pkg::CMP_W'(r_ways);
    assign w_count_ext = lcs_pkg::CMP_W'(r_count);
    always_comb begin
        if (w_ways_ext == '0) begin
            w_limit = lcs_pkg::CMP_W'(1);
        end else if (w_ways_ext > lcs_pkg::CMP_W'(MW)) begin
            w_limit = lcs_pkg::CMP_W'(MW);
        end else begin
            w_limit = w_ways_ext;
        end
    end

    // request decode; unused codes act as lookup
    always_comb begin
        w_req           = '0;
        w_req.en        = w_accept;
        w_req.tag       = lcs_pkg::t_tag'(s_tdata[19:0]);
        w_req.new_state = s_tdata[22:20];
        w_req.evict     = (w_count_ext >= w_limit) && (r_count != '0);
        case (lcs_pkg::t_op'(s_tuser))
            lcs_pkg::OP_READ_TOUCH: begin
                w_req.touch = 1'b1;
            end
            lcs_pkg::OP_UPDATE: begin
                w_req.touch  = 1'b1;
                w_req.use_ns = 1'b1;
            end
            lcs_pkg::OP_SET_STATE: begin
                w_req.set_st = 1'b1;
            end
            lcs_pkg::OP_INSERT: begin
                w_req.ins = 1'b1;
            end
            lcs_pkg::OP_INVALIDATE: begin
                w_req.inv = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // row of cells, oldest first; each takes shift data from its newer neighbor
    for (genvar g = 0; g < MW; g++) begin : g_cell
        lcs_pkg::t_link w_link_in;
        lcs_pkg::t_line w_nb;
        logic           w_prev_valid;

        if (g == 0) begin : g_first
            assign w_link_in    = '0;
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_link_in    = w_link[g-1];
            assign w_prev_valid = w_line[g-1].valid;
        end

        if (g == MW - 1) begin : g_end
            assign w_nb = '0;
        end else begin : g_inner
            assign w_nb = w_line[g+1];
        end

        lcs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_req        (w_req),
            .i_prev_valid (w_prev_valid),
            .i_link       (w_link_in),
            .i_nb         (w_nb),
            .o_line       (w_line[g]),
            .o_link       (w_link[g])
        );
    end

    assign w_hit = w_link[MW-1].found;

    // line count follows the cell row
    always_comb begin
        n_count = r_count;
        if (w_req.ins && !w_req.evict) begin
            n_count = r_count + lcs_pkg::CNT_W'(1);
        end else if (w_req.inv && w_hit) begin
            n_count = r_count - lcs_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways     <= lcs_pkg::WAYS_RESET;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == lcs_pkg::REG_WAYS)) begin
                r_ways <= pwdata[lcs_pkg::WAYS_W-1:0];
            end
            if (w_accept) begin
                r_count    <= n_count;
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_hit    <= w_hit;
            r_fstate <= w_link[MW-1].fstate;
        end
    end

    // after-step view comes straight from the cell row, which only moves
    // when the pending word leaves
    assign w_oldest = w_line[0];

    assign m_tdata[0]     = r_hit;
    assign m_tdata[3:1]   = r_fstate;
    assign m_tdata[4]     = (w_count_ext == w_limit);
    assign m_tdata[5]     = (r_count == '0);
    assign m_tdata[6]     = w_oldest.valid;
    assign m_tdata[26:7]  = w_oldest.valid ? lcs_pkg::TAG_W'(w_oldest.tag)
                                           : lcs_pkg::TAG_W'(0);
    assign m_tdata[29:27] = w_oldest.valid ? w_oldest.state : lcs_pkg::STATE_I;
    assign m_tdata[31:30] = 2'b00;

endmodule

FILE: rtl/lcs_checker.sv
module lcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // an accepted request gives a result word next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted request");

    // a miss reports the invalid state
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[3:1] == 3'd0)
        else $error("miss with non-invalid found state");

    // empty and oldest line valid are opposite, empty set shows a zero line
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[5] != m_tdata[6])
                     && (!m_tdata[5] || m_tdata[29:7] == 23'd0))
        else $error("empty flag and oldest line disagree");

endmodule

bind lru_cache_set_with_line_state_unit lcs_checker u_lcs_checker (.*);
